### src/lsvc_pkg.sv
// Shared constants for the lane segment validity check.
// Used by the top level, the pipelined divider and the port checker.
package lsvc_pkg;

    // Coordinate and fixed point sizes
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int WIDE_BITS  = COORD_BITS + 1;
    localparam int DIV_BITS   = COORD_BITS + FRAC_BITS;

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint SAT = longint'(1) << DIV_BITS;

    // Blend coefficients 0.1, 0.3 and their difference in Q.FRAC_BITS
    localparam longint C01 = (ONE + 5) / 10;
    localparam longint C03 = (3 * ONE + 5) / 10;
    localparam longint C02 = C03 - C01;

    // Verdict codes
    localparam int VERDICT_W = 3;
    localparam logic [VERDICT_W-1:0] VERDICT_LEFT  = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_RIGHT = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_WRONG = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_SHORT = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_SLOPE = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VANISH_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VANISH_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_LIMIT = 3'd4;

    // Register reset values
    localparam logic [COORD_BITS-1:0] RST_VANISH_X     = 12'd0;
    localparam logic [COORD_BITS-1:0] RST_VANISH_Y     = 12'd0;
    localparam logic [WIDE_BITS-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [WIDE_BITS-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [COORD_BITS-1:0] RST_BOTTOM_LIMIT = 12'd447;

endpackage

### src/lane_segment_validity_check.sv
// Lane segment validity check: classifies one line segment against the vanishing point.
// Depends on lsvc_pkg and lsvc_div.
// Path: stages 0 and 1, the two 28-stage dividers (ratios t and h), stages E1 to E5.
// Throughput: one segment per cycle while the shown verdict is not stalled.
// The whole pipeline holds while a shown verdict is stalled.
// Reset clears all valid bits and loads the configuration registers with their defaults.
module lane_segment_validity_check (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lsvc_pkg::COORD_BITS-1:0]      start_x,
    input  logic [lsvc_pkg::COORD_BITS-1:0]      start_y,
    input  logic [lsvc_pkg::COORD_BITS-1:0]      end_x,
    input  logic [lsvc_pkg::COORD_BITS-1:0]      end_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lsvc_pkg::VERDICT_W-1:0]       verdict,
    input  logic                                 cfg_we,
    input  logic [lsvc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsvc_pkg::WIDE_BITS-1:0]       cfg_data
);

    localparam int CB   = lsvc_pkg::COORD_BITS;
    localparam int FB   = lsvc_pkg::FRAC_BITS;
    localparam int DB   = lsvc_pkg::DIV_BITS;
    localparam int WB   = lsvc_pkg::WIDE_BITS;
    localparam int DW   = CB + 1;          // endpoint difference
    localparam int SW   = CB + 3;          // endpoint sums and normal terms
    localparam int PW   = 2 * SW;          // side products
    localparam int LW   = 2 * CB + 1;      // squared length
    localparam int TW   = DB + 2;          // ratios t and h
    localparam int THW  = DB + 6;          // length threshold
    localparam int THU  = DB + 4;          // positive threshold magnitude
    localparam int TCW  = TW + FB;         // ratio times blend coefficient
    localparam int KXW  = TW + 3;          // maximum slope bound
    localparam int MNW  = TW + DW + 1;     // minimum bound times |dx|
    localparam int MXW  = KXW + DW + 1;    // maximum bound times |dx|
    localparam int CMPW = MXW + 1;
    localparam int SBL  = DB - 1;          // side line length up to the divider output
    localparam int NST  = DB + 7;          // total pipeline stages

    typedef struct packed {
        logic          right;
        logic          wrong;
        logic [LW-1:0] len2;
        logic [CB-1:0] adx;
        logic [CB-1:0] ady;
        logic          t_neg;
        logic          tnum_zero;
        logic          tnum_neg;
        logic          tden_zero;
        logic          hnum_zero;
        logic          hden_zero;
    } side_t;

    // Configuration registers
    logic [CB-1:0] vanish_x_reg;
    logic [CB-1:0] vanish_y_reg;
    logic [WB-1:0] image_width_reg;
    logic [WB-1:0] image_height_reg;
    logic [CB-1:0] bottom_limit_reg;

    // Write one configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vanish_x_reg     <= lsvc_pkg::RST_VANISH_X;
            vanish_y_reg     <= lsvc_pkg::RST_VANISH_Y;
            image_width_reg  <= lsvc_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= lsvc_pkg::RST_IMAGE_HEIGHT;
            bottom_limit_reg <= lsvc_pkg::RST_BOTTOM_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsvc_pkg::CFG_VANISH_X:     vanish_x_reg     <= cfg_data[CB-1:0];
                lsvc_pkg::CFG_VANISH_Y:     vanish_y_reg     <= cfg_data[CB-1:0];
                lsvc_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                lsvc_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                lsvc_pkg::CFG_BOTTOM_LIMIT: bottom_limit_reg <= cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless the shown verdict is stalled
    logic adv;
    logic [NST-1:0] vld_reg;

    assign adv       = !(vld_reg[NST-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NST-1];

    // Shift the valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // Stage 0: register the endpoints
    logic [CB-1:0] s0_x1_reg, s0_y1_reg, s0_x2_reg, s0_y2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x1_reg <= start_x;
            s0_y1_reg <= start_y;
            s0_x2_reg <= end_x;
            s0_y2_reg <= end_y;
        end
    end

    // Stage 1: differences, normal terms and divider operands
    logic [CB-1:0]        half;
    logic signed [DW-1:0] s1_dx_next, s1_dy_next, s1_tnum_next, s1_tden_next;
    logic signed [SW-1:0] s1_ax_next, s1_by_next, s1_nx_next, s1_ny_next;
    logic [CB-1:0]        ybot, xd1, xd2, s1_xside_next;
    logic [DW-1:0]        tnum_abs, tden_abs;

    always_comb
    begin
        half         = image_width_reg[WB-1:1];
        s1_dx_next   = $signed({1'b0, s0_x2_reg}) - $signed({1'b0, s0_x1_reg});
        s1_dy_next   = $signed({1'b0, s0_y2_reg}) - $signed({1'b0, s0_y1_reg});
        s1_ax_next   = $signed({3'b0, s0_x1_reg}) + $signed({3'b0, s0_x2_reg})
                     - $signed({2'b0, vanish_x_reg, 1'b0});
        s1_by_next   = $signed({3'b0, s0_y1_reg}) + $signed({3'b0, s0_y2_reg})
                     - $signed({2'b0, vanish_y_reg, 1'b0});
        s1_nx_next   = $signed({2'b0, image_height_reg}) - SW'(1)
                     - $signed({3'b0, vanish_y_reg});
        s1_ny_next   = $signed({3'b0, vanish_x_reg}) - $signed({3'b0, half});
        ybot         = (s0_y1_reg > s0_y2_reg) ? s0_y1_reg : s0_y2_reg;
        s1_tnum_next = $signed({1'b0, ybot}) - $signed({1'b0, vanish_y_reg});
        s1_tden_next = $signed({1'b0, bottom_limit_reg}) - $signed({1'b0, vanish_y_reg});
        tnum_abs     = s1_tnum_next[DW-1] ? DW'(-s1_tnum_next) : DW'(s1_tnum_next);
        tden_abs     = s1_tden_next[DW-1] ? DW'(-s1_tden_next) : DW'(s1_tden_next);
        xd1          = (s0_x1_reg >= vanish_x_reg) ? s0_x1_reg - vanish_x_reg
                                                   : vanish_x_reg - s0_x1_reg;
        xd2          = (s0_x2_reg >= vanish_x_reg) ? s0_x2_reg - vanish_x_reg
                                                   : vanish_x_reg - s0_x2_reg;
        s1_xside_next = (xd1 > xd2) ? xd1 : xd2;
    end

    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;
    logic signed [SW-1:0] s1_ax_reg, s1_by_reg, s1_nx_reg, s1_ny_reg;
    logic [CB-1:0]        s1_tnum_reg, s1_tden_reg, s1_xside_reg, s1_half_reg;
    logic                 s1_tnum_neg_reg, s1_tden_neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg       <= s1_dx_next;
            s1_dy_reg       <= s1_dy_next;
            s1_ax_reg       <= s1_ax_next;
            s1_by_reg       <= s1_by_next;
            s1_nx_reg       <= s1_nx_next;
            s1_ny_reg       <= s1_ny_next;
            s1_tnum_reg     <= tnum_abs[CB-1:0];
            s1_tden_reg     <= tden_abs[CB-1:0];
            s1_tnum_neg_reg <= s1_tnum_next[DW-1];
            s1_tden_neg_reg <= s1_tden_next[DW-1];
            s1_xside_reg    <= s1_xside_next;
            s1_half_reg     <= half;
        end
    end

    // Ratio dividers
    logic [DB-1:0] quo_t, quo_h;

    lsvc_div u_div_t (
        .clk (clk),
        .en  (adv),
        .num (s1_tnum_reg),
        .den (s1_tden_reg),
        .quo (quo_t)
    );

    lsvc_div u_div_h (
        .clk (clk),
        .en  (adv),
        .num (s1_xside_reg),
        .den (s1_half_reg),
        .quo (quo_h)
    );

    // Stage 2: side products and squared components
    logic signed [PW-1:0]   s2_p1_reg, s2_p2_reg;
    logic signed [2*DW-1:0] s2_dx2_reg, s2_dy2_reg;
    logic signed [DW-1:0]   s2_dx_reg, s2_dy_reg;
    logic                   s2_t_neg_reg, s2_tnum_zero_reg, s2_tnum_neg_reg;
    logic                   s2_tden_zero_reg, s2_hnum_zero_reg, s2_hden_zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_p1_reg        <= PW'(s1_ax_reg) * PW'(s1_nx_reg);
            s2_p2_reg        <= PW'(s1_by_reg) * PW'(s1_ny_reg);
            s2_dx2_reg       <= (2*DW)'(s1_dx_reg) * (2*DW)'(s1_dx_reg);
            s2_dy2_reg       <= (2*DW)'(s1_dy_reg) * (2*DW)'(s1_dy_reg);
            s2_dx_reg        <= s1_dx_reg;
            s2_dy_reg        <= s1_dy_reg;
            s2_t_neg_reg     <= s1_tnum_neg_reg ^ s1_tden_neg_reg;
            s2_tnum_zero_reg <= (s1_tnum_reg == '0);
            s2_tnum_neg_reg  <= s1_tnum_neg_reg;
            s2_tden_zero_reg <= (s1_tden_reg == '0);
            s2_hnum_zero_reg <= (s1_xside_reg == '0);
            s2_hden_zero_reg <= (s1_half_reg == '0);
        end
    end

    // Stage 3: side decision, slope sign and squared length
    logic signed [PW:0]   dot;
    logic                 right, kpos, kneg;
    logic signed [DW-1:0] adx_s, ady_s;
    logic [2*DW-1:0]      len_sum;
    side_t                side_next;

    always_comb
    begin
        dot     = (PW+1)'(s2_p1_reg) + (PW+1)'(s2_p2_reg);
        right   = (dot > 0);
        kpos    = (s2_dy_reg > 0 && s2_dx_reg >= 0) || (s2_dy_reg < 0 && s2_dx_reg < 0);
        kneg    = (s2_dy_reg < 0 && s2_dx_reg >= 0) || (s2_dy_reg > 0 && s2_dx_reg < 0);
        adx_s   = s2_dx_reg[DW-1] ? -s2_dx_reg : s2_dx_reg;
        ady_s   = s2_dy_reg[DW-1] ? -s2_dy_reg : s2_dy_reg;
        len_sum = unsigned'(s2_dx2_reg) + unsigned'(s2_dy2_reg);

        side_next.right     = right;
        side_next.wrong     = !((right && kpos) || (!right && kneg));
        side_next.len2      = len_sum[LW-1:0];
        side_next.adx       = adx_s[CB-1:0];
        side_next.ady       = ady_s[CB-1:0];
        side_next.t_neg     = s2_t_neg_reg;
        side_next.tnum_zero = s2_tnum_zero_reg;
        side_next.tnum_neg  = s2_tnum_neg_reg;
        side_next.tden_zero = s2_tden_zero_reg;
        side_next.hnum_zero = s2_hnum_zero_reg;
        side_next.hden_zero = s2_hden_zero_reg;
    end

    // Hold the side data in step with the dividers
    side_t side_reg [SBL];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int j = 1; j < SBL; j++)
                side_reg[j] <= side_reg[j-1];
        end
    end

    // Stage E1: signed, saturated ratios
    logic signed [TW-1:0] sat_t, t_next, h_next, qt_s, qh_s;

    always_comb
    begin
        sat_t = TW'(lsvc_pkg::SAT);
        qt_s  = $signed({2'b0, quo_t});
        qh_s  = $signed({2'b0, quo_h});
        if (side_reg[SBL-1].tden_zero)
        begin
            if (side_reg[SBL-1].tnum_zero)
                t_next = '0;
            else if (side_reg[SBL-1].tnum_neg)
                t_next = -sat_t;
            else
                t_next = sat_t;
        end
        else
            t_next = side_reg[SBL-1].t_neg ? -qt_s : qt_s;

        if (side_reg[SBL-1].hden_zero)
            h_next = side_reg[SBL-1].hnum_zero ? '0 : sat_t;
        else
            h_next = qh_s;
    end

    logic signed [TW-1:0] e1_t_reg, e1_h_reg;
    side_t                e1_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_t_reg    <= t_next;
            e1_h_reg    <= h_next;
            e1_side_reg <= side_reg[SBL-1];
        end
    end

    // Stage E2: length threshold and blend products
    logic signed [THW-1:0] e2_thr_reg;
    logic signed [TCW-1:0] e2_tc_reg, e2_hc_reg;
    logic signed [TW-1:0]  e2_t_reg, e2_h_reg;
    side_t                 e2_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e2_thr_reg  <= THW'(e1_t_reg) * THW'(15) + THW'(10 * lsvc_pkg::ONE);
            e2_tc_reg   <= TCW'(e1_t_reg) * TCW'(lsvc_pkg::C02);
            e2_hc_reg   <= TCW'(e1_h_reg) * TCW'(lsvc_pkg::C02);
            e2_t_reg    <= e1_t_reg;
            e2_h_reg    <= e1_h_reg;
            e2_side_reg <= e1_side_reg;
        end
    end

    // Stage E3: threshold square and slope bounds
    logic signed [TCW-1:0] tc_adj, tc_q, hc_q;
    logic signed [TW:0]    kmin_sum, kmin_adj;
    logic signed [TW-1:0]  kmin_next;
    logic signed [KXW-1:0] kmax_next;
    logic [THU-1:0]        thr_mag;

    always_comb
    begin
        tc_adj    = e2_tc_reg + (e2_tc_reg[TCW-1] ? TCW'(lsvc_pkg::ONE - 1) : TCW'(0));
        tc_q      = tc_adj >>> FB;
        hc_q      = e2_hc_reg >>> FB;
        kmin_sum  = (TW+1)'(tc_q) + (TW+1)'(lsvc_pkg::C01 + lsvc_pkg::C03) - (TW+1)'(hc_q);
        kmin_adj  = kmin_sum + (kmin_sum[TW] ? (TW+1)'(1) : (TW+1)'(0));
        kmin_next = TW'(kmin_adj >>> 1);
        kmax_next = (KXW'(e2_t_reg) <<< 1) + KXW'(3 * lsvc_pkg::ONE)
                  - (KXW'(e2_h_reg) <<< 1);
        thr_mag   = e2_thr_reg[THU-1:0];
    end

    logic                  e3_thr_pos_reg;
    logic [2*THU-1:0]      e3_thr_sq_reg;
    logic signed [TW-1:0]  e3_kmin_reg;
    logic signed [KXW-1:0] e3_kmax_reg;
    side_t                 e3_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e3_thr_pos_reg <= (e2_thr_reg > 0);
            e3_thr_sq_reg  <= (2*THU)'(thr_mag) * (2*THU)'(thr_mag);
            e3_kmin_reg    <= kmin_next;
            e3_kmax_reg    <= kmax_next;
            e3_side_reg    <= e2_side_reg;
        end
    end

    // Stage E4: length compare and bound products
    logic signed [DW-1:0] adx_e4;
    logic [2*THU-1:0]     len_shifted;

    always_comb
    begin
        adx_e4      = $signed({1'b0, e3_side_reg.adx});
        len_shifted = (2*THU)'({e3_side_reg.len2, {(2*FB){1'b0}}});
    end

    logic                  e4_short_reg, e4_wrong_reg, e4_right_reg, e4_adx_zero_reg;
    logic signed [MNW-1:0] e4_mmin_reg;
    logic signed [MXW-1:0] e4_mmax_reg;
    logic [CB-1:0]         e4_ady_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e4_short_reg    <= e3_thr_pos_reg && (len_shifted < e3_thr_sq_reg);
            e4_mmin_reg     <= MNW'(e3_kmin_reg) * MNW'(adx_e4);
            e4_mmax_reg     <= MXW'(e3_kmax_reg) * MXW'(adx_e4);
            e4_wrong_reg    <= e3_side_reg.wrong;
            e4_right_reg    <= e3_side_reg.right;
            e4_adx_zero_reg <= (e3_side_reg.adx == '0);
            e4_ady_reg      <= e3_side_reg.ady;
        end
    end

    // Stage E5: slope compare and verdict
    logic signed [CMPW-1:0]      ady_one;
    logic                        bad_slope;
    logic [lsvc_pkg::VERDICT_W-1:0] verdict_next;

    always_comb
    begin
        ady_one   = $signed(CMPW'({e4_ady_reg, {FB{1'b0}}}));
        bad_slope = e4_adx_zero_reg
                 || (ady_one < CMPW'(e4_mmin_reg))
                 || (ady_one > CMPW'(e4_mmax_reg));
        if (e4_wrong_reg)
            verdict_next = lsvc_pkg::VERDICT_WRONG;
        else if (e4_short_reg)
            verdict_next = lsvc_pkg::VERDICT_SHORT;
        else if (bad_slope)
            verdict_next = lsvc_pkg::VERDICT_SLOPE;
        else if (e4_right_reg)
            verdict_next = lsvc_pkg::VERDICT_RIGHT;
        else
            verdict_next = lsvc_pkg::VERDICT_LEFT;
    end

    logic [lsvc_pkg::VERDICT_W-1:0] verdict_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            verdict_reg <= verdict_next;
    end

    assign verdict = verdict_reg;

endmodule

### src/lsvc_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit a stage.
// Depends on lsvc_pkg; a zero divisor gives a meaningless quotient.
module lsvc_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic [lsvc_pkg::COORD_BITS-1:0]  num,
    input  logic [lsvc_pkg::COORD_BITS-1:0]  den,
    output logic [lsvc_pkg::DIV_BITS-1:0]    quo
);

    localparam int CB = lsvc_pkg::COORD_BITS;
    localparam int FB = lsvc_pkg::FRAC_BITS;
    localparam int DB = lsvc_pkg::DIV_BITS;

    logic [CB-1:0] rem_reg [DB];
    logic [CB-1:0] den_reg [DB];
    logic [DB-1:0] dvd_reg [DB];
    logic [DB-1:0] quo_reg [DB];

    genvar k;
    generate
        for (k = 0; k < DB; k++) begin : g_stage
            logic [CB-1:0] rem_prev;
            logic [CB-1:0] den_prev;
            logic [DB-1:0] dvd_prev;
            logic [DB-1:0] quo_prev;
            logic [CB:0]   shifted;
            logic [CB:0]   diff;
            logic          ge;
            logic [CB-1:0] rem_next;

            // Take the previous stage, or the operands at the first stage
            if (k == 0) begin : g_first
                assign rem_prev = '0;
                assign den_prev = den;
                assign dvd_prev = {num, {FB{1'b0}}};
                assign quo_prev = '0;
            end else begin : g_rest
                assign rem_prev = rem_reg[k-1];
                assign den_prev = den_reg[k-1];
                assign dvd_prev = dvd_reg[k-1];
                assign quo_prev = quo_reg[k-1];
            end

            // Trial subtract of the divisor from the shifted remainder
            always_comb
            begin
                shifted  = {rem_prev, dvd_prev[DB-1]};
                diff     = shifted - {1'b0, den_prev};
                ge       = (shifted >= {1'b0, den_prev});
                rem_next = ge ? diff[CB-1:0] : shifted[CB-1:0];
            end

            // Advance one stage
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_prev;
                    dvd_reg[k] <= {dvd_prev[DB-2:0], 1'b0};
                    quo_reg[k] <= {quo_prev[DB-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DB-1];

endmodule

### src/lsvc_checker.sv
// Port-level checks for the lane segment validity check.
// Depends on lsvc_pkg; bound to the top level below.
module lsvc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [lsvc_pkg::VERDICT_W-1:0]  verdict
);

    // Input is held exactly while a shown verdict is stalled
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

    // A stalled verdict stays and holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict))
        else $error("stalled verdict dropped or changed");

    // Only defined verdict codes leave the block
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == lsvc_pkg::VERDICT_LEFT || verdict == lsvc_pkg::VERDICT_RIGHT
                    || verdict == lsvc_pkg::VERDICT_WRONG || verdict == lsvc_pkg::VERDICT_SHORT
                    || verdict == lsvc_pkg::VERDICT_SLOPE))
        else $error("undefined verdict code");

    // Nothing is shown while reset is held
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind lane_segment_validity_check lsvc_checker u_lsvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
);

### tb/testbench.sv
// Self-checking testbench for the lane segment validity check.
// Depends on lsvc_pkg and the top level; a scoreboard class predicts verdicts.
module testbench;

    // Verdict predictor holding its own copy of the configuration
    class scoreboard_t;
        logic [lsvc_pkg::COORD_BITS-1:0] vx, vy, bot;
        logic [lsvc_pkg::WIDE_BITS-1:0]  wid, hgt;
        logic [lsvc_pkg::VERDICT_W-1:0]  expected_q[$];
        int                              mismatches;

        function new();
            vx = lsvc_pkg::RST_VANISH_X;
            vy = lsvc_pkg::RST_VANISH_Y;
            wid = lsvc_pkg::RST_IMAGE_WIDTH;
            hgt = lsvc_pkg::RST_IMAGE_HEIGHT;
            bot = lsvc_pkg::RST_BOTTOM_LIMIT;
            mismatches = 0;
        endfunction

        function void set_reg(logic [lsvc_pkg::CFG_IDX_W-1:0] idx,
                              logic [lsvc_pkg::WIDE_BITS-1:0] data);
            case (idx)
                lsvc_pkg::CFG_VANISH_X:     vx = data[lsvc_pkg::COORD_BITS-1:0];
                lsvc_pkg::CFG_VANISH_Y:     vy = data[lsvc_pkg::COORD_BITS-1:0];
                lsvc_pkg::CFG_IMAGE_WIDTH:  wid = data;
                lsvc_pkg::CFG_IMAGE_HEIGHT: hgt = data;
                lsvc_pkg::CFG_BOTTOM_LIMIT: bot = data[lsvc_pkg::COORD_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Fixed point ratio, saturating on zero divisor and large magnitudes
        function longint fix_ratio(longint num, longint den);
            longint mag;
            if (den == 0)
                return num > 0 ? lsvc_pkg::SAT : (num < 0 ? -lsvc_pkg::SAT : 0);
            mag = ((num < 0 ? -num : num) <<< lsvc_pkg::FRAC_BITS) / (den < 0 ? -den : den);
            if (mag > lsvc_pkg::SAT)
                mag = lsvc_pkg::SAT;
            return ((num < 0) != (den < 0)) ? -mag : mag;
        endfunction

        function logic [lsvc_pkg::VERDICT_W-1:0] classify(longint x1, longint y1,
                                                          longint x2, longint y2);
            longint dx, dy, adx, ady, half, nx, ny, dot, ybot, s1, s2, xside;
            longint t, h, thr, kmin, kmax;
            logic [127:0] len_sq, thr_sq;
            bit right, kpos, kneg;
            dx = x2 - x1;
            dy = y2 - y1;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            half = longint'(wid) / 2;
            nx = longint'(hgt) - 1 - longint'(vy);
            ny = longint'(vx) - half;
            dot = (x1 + x2 - 2 * longint'(vx)) * nx + (y1 + y2 - 2 * longint'(vy)) * ny;
            right = dot > 0;
            kpos = (dy > 0 && dx >= 0) || (dy < 0 && dx < 0);
            kneg = (dy < 0 && dx >= 0) || (dy > 0 && dx < 0);
            if (!((right && kpos) || (!right && kneg)))
                return lsvc_pkg::VERDICT_WRONG;
            ybot = y1 > y2 ? y1 : y2;
            s1 = x1 - longint'(vx);
            s1 = s1 < 0 ? -s1 : s1;
            s2 = x2 - longint'(vx);
            s2 = s2 < 0 ? -s2 : s2;
            xside = s1 > s2 ? s1 : s2;
            t = fix_ratio(ybot - longint'(vy), longint'(bot) - longint'(vy));
            h = fix_ratio(xside, half);
            // Compare squared length against squared threshold exactly
            thr = 15 * t + 10 * lsvc_pkg::ONE;
            if (thr > 0)
            begin
                len_sq = 128'(dx * dx + dy * dy) << (2 * lsvc_pkg::FRAC_BITS);
                thr_sq = 128'(thr) * 128'(thr);
                if (len_sq < thr_sq)
                    return lsvc_pkg::VERDICT_SHORT;
            end
            kmin = ((t * lsvc_pkg::C02) / lsvc_pkg::ONE + lsvc_pkg::C01 + lsvc_pkg::C03
                    - (h * lsvc_pkg::C02) / lsvc_pkg::ONE) / 2;
            kmax = (4 * t + lsvc_pkg::ONE + 5 * lsvc_pkg::ONE - 4 * h) / 2;
            if (adx == 0 || ady * lsvc_pkg::ONE < kmin * adx
                || ady * lsvc_pkg::ONE > kmax * adx)
                return lsvc_pkg::VERDICT_SLOPE;
            return right ? lsvc_pkg::VERDICT_RIGHT : lsvc_pkg::VERDICT_LEFT;
        endfunction

        function void note_segment(logic [lsvc_pkg::COORD_BITS-1:0] x1,
                                   logic [lsvc_pkg::COORD_BITS-1:0] y1,
                                   logic [lsvc_pkg::COORD_BITS-1:0] x2,
                                   logic [lsvc_pkg::COORD_BITS-1:0] y2);
            expected_q = {expected_q, classify(x1, y1, x2, y2)};
        endfunction

        function void check_verdict(logic [lsvc_pkg::VERDICT_W-1:0] got);
            logic [lsvc_pkg::VERDICT_W-1:0] want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict %0d with nothing pending", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("verdict mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                            clk, rst_n;
    logic                            in_valid, in_stall, out_valid, out_stall;
    logic [lsvc_pkg::COORD_BITS-1:0] start_x, start_y, end_x, end_y;
    logic [lsvc_pkg::VERDICT_W-1:0]  verdict;
    logic                            cfg_we;
    logic [lsvc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lsvc_pkg::WIDE_BITS-1:0]  cfg_data;

    scoreboard_t sb;
    bit  steady_flow;   // no idling on either side while set
    int  hold_request;  // receiver hold-off length, picked up by the receiver

    lane_segment_validity_check dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 1000000);
        $display("[lane_segment_validity_check] ERROR");
        $finish;
    end

    // Drive one segment and hold it until it is taken
    task send_segment(int x1, int y1, int x2, int y2);
        while (!steady_flow && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= x1[lsvc_pkg::COORD_BITS-1:0];
        start_y <= y1[lsvc_pkg::COORD_BITS-1:0];
        end_x <= x2[lsvc_pkg::COORD_BITS-1:0];
        end_y <= y2[lsvc_pkg::COORD_BITS-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_segment(x1[lsvc_pkg::COORD_BITS-1:0], y1[lsvc_pkg::COORD_BITS-1:0],
                        x2[lsvc_pkg::COORD_BITS-1:0], y2[lsvc_pkg::COORD_BITS-1:0]);
    endtask

    task write_reg(logic [lsvc_pkg::CFG_IDX_W-1:0] idx, int data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[lsvc_pkg::WIDE_BITS-1:0];
        @(posedge clk);
        sb.set_reg(idx, data[lsvc_pkg::WIDE_BITS-1:0]);
    endtask

    // Wait until every pending verdict has arrived, then let the pipe settle
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task load_config(int vx, int vy, int w, int h, int b);
        drain();
        write_reg(lsvc_pkg::CFG_VANISH_X, vx);
        write_reg(lsvc_pkg::CFG_VANISH_Y, vy);
        write_reg(lsvc_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(lsvc_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(lsvc_pkg::CFG_BOTTOM_LIMIT, b);
        cfg_we <= 1'b0;
    endtask

    function int clamp_coord(int v);
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    // Mostly lane-like segments pointing at the vanishing point, the rest noise
    task random_segments(int count);
        int ya, yb, k, sgn, xa, xb;
        repeat (count)
        begin
            if ($urandom_range(99) < 70)
            begin
                ya = int'(sb.vy) + int'($urandom_range(0, 400));
                yb = ya + int'($urandom_range(1, 150));
                k = int'($urandom_range(2, 24));
                sgn = $urandom_range(1) ? 1 : -1;
                xa = clamp_coord(int'(sb.vx) + sgn * (ya - int'(sb.vy)) * k / 8
                                 + int'($urandom_range(0, 6)) - 3);
                xb = clamp_coord(int'(sb.vx) + sgn * (yb - int'(sb.vy)) * k / 8
                                 + int'($urandom_range(0, 6)) - 3);
                ya = clamp_coord(ya);
                yb = clamp_coord(yb);
                if ($urandom_range(1))
                    send_segment(xa, ya, xb, yb);
                else
                    send_segment(xb, yb, xa, ya);
            end
            else
            begin
                send_segment($urandom_range(4095), $urandom_range(4095),
                             $urandom_range(4095), $urandom_range(4095));
            end
        end
    endtask

    // Receiver: check accepted verdicts, stall at random or on a hold-off
    initial
    begin
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_verdict(verdict);
            if (hold_request > 0)
            begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady_flow && $urandom_range(99) < 30;
        end
    end

    initial
    begin
        sb = new();
        steady_flow = 0;
        hold_request = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, points, horizontal, vertical, short, lane-like
        send_segment(0, 0, 0, 0);
        send_segment(4095, 4095, 4095, 4095);
        send_segment(0, 0, 4095, 4095);
        send_segment(4095, 0, 0, 4095);
        send_segment(0, 4095, 4095, 0);
        send_segment(100, 300, 400, 300);
        send_segment(300, 100, 300, 400);
        send_segment(600, 100, 600, 470);
        send_segment(200, 400, 202, 403);
        send_segment(100, 100, 300, 400);
        send_segment(300, 400, 100, 100);
        send_segment(500, 100, 200, 400);
        send_segment(200, 400, 500, 100);
        send_segment(10, 440, 13, 446);
        send_segment(4095, 0, 4095, 4095);
        send_segment(0, 4095, 0, 0);
        send_segment(640, 479, 0, 0);
        send_segment(320, 240, 330, 260);
        random_segments(230);

        load_config(2048, 1000, 4096, 4096, 4000);
        random_segments(250);
        // Extremes, bottom limit equal to vanishing row
        load_config(4095, 4095, 8191, 0, 4095);
        random_segments(200);
        // Smallest image, zero divisor on the vertical ratio
        load_config(0, 0, 2, 1, 0);
        random_segments(200);
        // Zero half width; receiver holds off while the sender keeps offering
        load_config(320, 200, 1, 480, 200);
        hold_request = 300;
        random_segments(250);
        // Realistic setting with upper data bits set on narrow registers
        load_config(13'h1280, 13'h10f0, 1280, 720, 13'h12bc);
        steady_flow = 1;
        random_segments(200);
        steady_flow = 0;
        random_segments(100);

        drain();
        if (sb.mismatches == 0)
            $display("[lane_segment_validity_check] OK");
        else
            $display("[lane_segment_validity_check] ERROR");
        $finish;
    end
endmodule

### filelist.f
src/lsvc_pkg.sv
src/lsvc_div.sv
src/lane_segment_validity_check.sv
src/lsvc_checker.sv
tb/testbench.sv
